>>> hw/rtl/cfr_pkg.sv
// cfr_pkg: shared types and constants for the CO2 frame checksum receiver.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int FRAME_BYTES_DEF = 12;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 16;
    localparam int READING_W = 16;
    localparam int RETRY_W   = 11;
    localparam int STATUS_W  = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_READING_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT   = 2'd1;

    localparam logic [READING_W-1:0] READING_LIMIT_RST = 16'd3000;
    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST   = 11'd1000;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RETRY   = 2'd1,
        STATUS_TIMEOUT = 2'd2,
        STATUS_RANGE   = 2'd3
    } status_e;

    // What the frame tracker reports about the item at the head of the pipe
    typedef struct packed {
        logic                 last;     // item is the final byte of a frame
        logic                 match;    // checksum bytes equal the payload sum
        logic [READING_W-1:0] reading;  // captured big-endian reading
    } frame_info_t;

endpackage

>>> hw/rtl/cfr_frame.sv
// cfr_frame: byte position, running payload sum, checksum high byte and
// reading capture. Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_frame #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [cfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       frame_start,
    output cfr_pkg::frame_info_t       info
);
    import cfr_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_RD_HI  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_RD_LO  = POS_W'(5);

    logic [POS_W-1:0]     pos_reg, pos_next, pos_cur;
    logic [SUM_W-1:0]     sum_reg, sum_next, sum_cur;
    logic [BYTE_W-1:0]    chk_hi_reg, chk_hi_next;
    logic [READING_W-1:0] cap_reg, cap_next;
    logic                 last;

    always_comb
    begin
        pos_cur     = frame_start ? '0 : pos_reg;
        sum_cur     = frame_start ? '0 : sum_reg;
        pos_next    = pos_cur + POS_W'(1);
        sum_next    = sum_cur;
        chk_hi_next = chk_hi_reg;
        cap_next    = cap_reg;
        last        = 1'b0;
        priority if (pos_cur < POS_CHK_HI)
        begin
            sum_next = sum_cur + SUM_W'(rx_byte);
            if (pos_cur == POS_RD_HI)
                cap_next = {rx_byte, cap_reg[BYTE_W-1:0]};
            else if (pos_cur == POS_RD_LO)
                cap_next = {cap_reg[READING_W-1:BYTE_W], rx_byte};
        end
        else if (pos_cur == POS_CHK_HI)
        begin
            chk_hi_next = rx_byte;
        end
        else
        begin
            // final byte: frame closes, next byte starts over
            last     = 1'b1;
            pos_next = '0;
            sum_next = '0;
        end
    end

    assign info.last    = last;
    assign info.match   = ({chk_hi_reg, rx_byte} == sum_cur);
    assign info.reading = cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            chk_hi_reg <= '0;
            cap_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            chk_hi_reg <= chk_hi_next;
            cap_reg    <= cap_next;
        end
    end

endmodule

>>> hw/rtl/cfr_verdict.sv
// cfr_verdict: failure counter, per-frame status decision and the result
// register of the output channel. Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_verdict (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  cfr_pkg::frame_info_t          info,
    input  logic [cfr_pkg::READING_W-1:0] reading_limit,
    input  logic [cfr_pkg::RETRY_W-1:0]   retry_limit,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cfr_pkg::STATUS_W-1:0]  status,
    output logic [cfr_pkg::READING_W-1:0] reading_ppm
);
    import cfr_pkg::*;

    logic [RETRY_W-1:0]   fail_reg, fail_next;
    logic [RETRY_W:0]     fail_plus;
    logic                 out_valid_reg, out_valid_next;
    status_e              status_reg, status_next;
    logic [READING_W-1:0] reading_reg, reading_next;
    logic                 load;

    assign load      = step && info.last;
    assign fail_plus = {1'b0, fail_reg} + (RETRY_W + 1)'(1);

    always_comb
    begin
        fail_next    = fail_reg;
        status_next  = STATUS_RETRY;
        reading_next = '0;
        if (info.match)
        begin
            fail_next    = '0;
            reading_next = info.reading;
            status_next  = (info.reading < reading_limit) ? STATUS_OK : STATUS_RANGE;
        end
        else if (fail_plus > {1'b0, retry_limit})
        begin
            fail_next   = '0;
            status_next = STATUS_TIMEOUT;
        end
        else
        begin
            fail_next = fail_plus[RETRY_W-1:0];
        end
    end

    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
                fail_reg <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= status_next;
            reading_reg <= reading_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign reading_ppm = reading_reg;

endmodule

>>> hw/rtl/co2_frame_checksum_receiver.sv
// co2_frame_checksum_receiver: top level. Input register, configuration
// registers and handshake control. Depends on cfr_pkg, cfr_frame, cfr_verdict.
`timescale 1ns / 1ps

// Receives a CO2 sensor reply one byte per item on the input channel
// (rx_byte, frame_start; in_valid / in_stall). frame_start forces the byte
// to position zero; after the last byte of a frame the next byte starts a
// new frame on its own. Every byte but the final two is summed; the final
// two are the big-endian checksum. One item leaves on the output channel
// (status, reading_ppm; out_valid / out_stall) per complete frame.
// A frame-closing item passes the input register and then the result
// register before it is shown on the output. Throughput: one byte per
// cycle while in_stall is low, set by the single input register feeding
// the frame state update. While the output register holds a stalled
// result, bytes keep flowing until a frame-closing byte reaches the input
// register; only then is in_stall raised. Configuration (cfg_valid /
// cfg_ready, cfg_index, cfg_data) is always ready; the user must write it
// only while no frame is in flight, which the block does not enforce.
// Reset clears position, sum, failure count and both channels, and loads
// reading_limit = 3000 and retry_limit = 1000.
module co2_frame_checksum_receiver #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cfr_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                            frame_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cfr_pkg::STATUS_W-1:0]    status,
    output logic [cfr_pkg::READING_W-1:0]   reading_ppm,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cfr_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]    rx_byte_reg;
    logic                 frame_start_reg;
    logic                 accept, step, out_free;
    frame_info_t          info;
    logic [READING_W-1:0] reading_limit_reg;
    logic [RETRY_W-1:0]   retry_limit_reg;

    // a byte that closes no frame never waits on the output side
    assign step          = in_valid_reg && (!info.last || out_free);
    assign in_stall      = in_valid_reg && !step;
    assign accept        = in_valid && !in_stall;
    assign in_valid_next = accept || (in_valid_reg && !step);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_byte_reg     <= rx_byte;
            frame_start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_limit_reg <= READING_LIMIT_RST;
            retry_limit_reg   <= RETRY_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_READING_LIMIT: reading_limit_reg <= cfg_data[READING_W-1:0];
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[RETRY_W-1:0];
                default:           ;
            endcase
        end
    end

    cfr_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (rx_byte_reg),
        .frame_start (frame_start_reg),
        .info        (info)
    );

    cfr_verdict u_verdict (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .info          (info),
        .reading_limit (reading_limit_reg),
        .retry_limit   (retry_limit_reg),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .reading_ppm   (reading_ppm)
    );

endmodule

>>> hw/rtl/cfr_checker.sv
// cfr_assert: port-level assertions for the frame checksum receiver and
// the bind that attaches them to the top level. Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_assert (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [cfr_pkg::STATUS_W-1:0]  status,
    input logic [cfr_pkg::READING_W-1:0] reading_ppm
);
    import cfr_pkg::*;

    // held result stays put while the output is stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(reading_ppm))
        else $error("stalled result changed");

    // input only backs up behind a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a fresh result must be preceded by an accepted input item
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching accepted item");

    // failed frames carry no reading
    a_fail_reading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_RETRY || status == STATUS_TIMEOUT)
            |-> reading_ppm == '0)
        else $error("reading reported on failed frame");

endmodule

bind co2_frame_checksum_receiver cfr_assert u_cfr_assert (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .reading_ppm (reading_ppm)
);
